### src/rsi_pkg.sv
// Shared types and constants of the ray/sphere intersection pipeline.
// No dependencies; rsi_front, rsi_div, top level and bench import it.
package rsi_pkg;

  localparam int FIELD_W = 32;  // width of a coordinate field on the port
  localparam int DIST_W  = 31;  // radius, distance bound and result distance
  localparam int EPS_W   = 16;  // epsilon register
  localparam int FRAC_W  = 16;  // fraction bits of Q16.16

  localparam logic [EPS_W-1:0] EPS_RESET = 16'd66;

  typedef struct packed {
    logic signed [FIELD_W-1:0] origin_x;
    logic signed [FIELD_W-1:0] origin_y;
    logic signed [FIELD_W-1:0] origin_z;
    logic signed [FIELD_W-1:0] direction_x;
    logic signed [FIELD_W-1:0] direction_y;
    logic signed [FIELD_W-1:0] direction_z;
    logic signed [FIELD_W-1:0] center_x;
    logic signed [FIELD_W-1:0] center_y;
    logic signed [FIELD_W-1:0] center_z;
    logic [DIST_W-1:0]         sphere_radius;
    logic [DIST_W-1:0]         max_distance;
  } rsi_in_t;

  typedef struct packed {
    logic              hit;
    logic [DIST_W-1:0] distance;
  } rsi_out_t;

endpackage

### src/rsi_mul.sv
// Two-stage signed multiplier: four registered half-width partial products,
// then a registered sum. No package dependency.
module rsi_mul #(
  parameter int AW = 33,
  parameter int BW = 33
) (
  input  logic                    clk,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);

  localparam int AL = AW / 2;
  localparam int AH = AW - AL;
  localparam int BL = BW / 2;
  localparam int BH = BW - BL;
  localparam int PW = AW + BW;

  logic signed [AL:0]       a_lo;
  logic signed [AH-1:0]     a_hi;
  logic signed [BL:0]       b_lo;
  logic signed [BH-1:0]     b_hi;
  logic signed [AL+BL+1:0]  pp_ll;
  logic signed [AL+BH:0]    pp_lh;
  logic signed [AH+BL:0]    pp_hl;
  logic signed [AH+BH-1:0]  pp_hh;

  // low halves are unsigned, high halves carry the sign
  assign a_lo = $signed({1'b0, a[AL-1:0]});
  assign a_hi = a[AW-1:AL];
  assign b_lo = $signed({1'b0, b[BL-1:0]});
  assign b_hi = b[BW-1:BL];

  always_ff @(posedge clk) begin
    pp_ll <= a_lo * b_lo;
    pp_lh <= a_lo * b_hi;
    pp_hl <= a_hi * b_lo;
    pp_hh <= a_hi * b_hi;
    p     <= (PW'(pp_hh) <<< (AL + BL)) + (PW'(pp_hl) <<< AL)
           + (PW'(pp_lh) <<< BL) + PW'(pp_ll);
  end

endmodule

### src/rsi_front.sv
// Front of the pipeline: offset vector, dot products, quadratic terms and
// discriminant. Depends on rsi_pkg and rsi_mul.
module rsi_front #(
  parameter int W = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        vld_in,
  input  rsi_pkg::rsi_in_t            in_data,
  output logic                        vld,
  output logic                        miss,
  output logic [2*W-1:0]              a,
  output logic signed [2*W+1:0]       hb,
  output logic signed [4*W+3:0]       disc,
  output logic [rsi_pkg::DIST_W-1:0]  maxd
);

  import rsi_pkg::*;

  localparam int AW = 2 * W;
  localparam int HW = 2 * W + 2;
  localparam int CW = 2 * W + 3;
  localparam int DW = 4 * W + 4;

  function automatic logic signed [W-1:0] to_coord(input logic [FIELD_W-1:0] f);
    logic [W+FIELD_W-1:0] ext;
    begin
      ext = {{W{1'b0}}, f};
      return ext[W-1:0];
    end
  endfunction

  logic signed [W:0]      o [3];
  logic signed [W-1:0]    d [3];
  logic signed [W-1:0]    r1;
  logic [W+DIST_W-1:0]    rext;
  logic signed [2*W-1:0]  dd [3];
  logic signed [2*W:0]    od [3];
  logic signed [2*W+1:0]  oo [3];
  logic signed [2*W-1:0]  rr;
  logic                   vld1, vld2, vld3, vld4, vld5, vld6;
  logic [DIST_W-1:0]      maxd1, maxd2, maxd3, maxd4, maxd5, maxd6;
  logic signed [AW+1:0]   a_sum;
  logic signed [HW-1:0]   hb_sum;
  logic signed [CW-1:0]   c_sum;
  logic [AW-1:0]          a4, a5, a6;
  logic signed [HW-1:0]   hb4, hb5, hb6;
  logic signed [CW-1:0]   c4;
  logic signed [DW-1:0]   hh, ac, disc_c;

  assign rext = {{W{1'b0}}, in_data.sphere_radius};

  always_ff @(posedge clk) begin
    o[0]  <= (W+1)'(to_coord(in_data.origin_x)) - (W+1)'(to_coord(in_data.center_x));
    o[1]  <= (W+1)'(to_coord(in_data.origin_y)) - (W+1)'(to_coord(in_data.center_y));
    o[2]  <= (W+1)'(to_coord(in_data.origin_z)) - (W+1)'(to_coord(in_data.center_z));
    d[0]  <= to_coord(in_data.direction_x);
    d[1]  <= to_coord(in_data.direction_y);
    d[2]  <= to_coord(in_data.direction_z);
    r1    <= $signed({1'b0, rext[W-2:0]});
    maxd1 <= in_data.max_distance;
  end

  for (genvar i = 0; i < 3; i++) begin : g_dot
    rsi_mul #(.AW(W),   .BW(W))   u_dd (.clk(clk), .a(d[i]), .b(d[i]), .p(dd[i]));
    rsi_mul #(.AW(W+1), .BW(W))   u_od (.clk(clk), .a(o[i]), .b(d[i]), .p(od[i]));
    rsi_mul #(.AW(W+1), .BW(W+1)) u_oo (.clk(clk), .a(o[i]), .b(o[i]), .p(oo[i]));
  end

  rsi_mul #(.AW(W), .BW(W)) u_rr (.clk(clk), .a(r1), .b(r1), .p(rr));

  always_comb begin
    a_sum  = (AW+2)'(dd[0]) + (AW+2)'(dd[1]) + (AW+2)'(dd[2]);
    hb_sum = HW'(od[0]) + HW'(od[1]) + HW'(od[2]);
    c_sum  = CW'(oo[0]) + CW'(oo[1]) + CW'(oo[2]) - CW'(rr);
  end

  always_ff @(posedge clk) begin
    a4  <= a_sum[AW-1:0];
    hb4 <= hb_sum;
    c4  <= c_sum;
  end

  rsi_mul #(.AW(HW),   .BW(HW)) u_hh (.clk(clk), .a(hb4), .b(hb4), .p(hh));
  rsi_mul #(.AW(AW+1), .BW(CW)) u_ac (.clk(clk), .a($signed({1'b0, a4})), .b(c4), .p(ac));

  assign disc_c = hh - ac;

  always_ff @(posedge clk) begin
    maxd2 <= maxd1;
    maxd3 <= maxd2;
    maxd4 <= maxd3;
    maxd5 <= maxd4;
    maxd6 <= maxd5;
    a5    <= a4;
    a6    <= a5;
    hb5   <= hb4;
    hb6   <= hb5;
    disc  <= disc_c;
    miss  <= (a6 == '0) || disc_c[DW-1];
    a     <= a6;
    hb    <= hb6;
    maxd  <= maxd6;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
      vld4 <= 1'b0;
      vld5 <= 1'b0;
      vld6 <= 1'b0;
      vld  <= 1'b0;
    end else begin
      vld1 <= vld_in;
      vld2 <= vld1;
      vld3 <= vld2;
      vld4 <= vld3;
      vld5 <= vld4;
      vld6 <= vld5;
      vld  <= vld6;
    end
  end

endmodule

### src/rsi_sqrt.sv
// Integer square root, one result bit per pipeline stage, with sideband
// carried alongside. No package dependency.
module rsi_sqrt #(
  parameter int DW = 132,
  parameter int XW = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              vld_in,
  input  logic [DW-1:0]     x,
  input  logic [XW-1:0]     side_in,
  output logic              vld,
  output logic [DW/2-1:0]   root,
  output logic [XW-1:0]     side
);

  localparam int SW  = DW / 2;
  localparam int RMW = SW + 2;

  logic              vld_q  [SW];
  logic [RMW-1:0]    rem_q  [SW];
  logic [SW-1:0]     root_q [SW];
  logic [DW-1:0]     x_q    [SW];
  logic [XW-1:0]     side_q [SW];

  for (genvar k = 0; k < SW; k++) begin : g_stage
    logic           vld_p;
    logic [RMW-1:0] rem_p;
    logic [SW-1:0]  root_p;
    logic [DW-1:0]  x_p;
    logic [XW-1:0]  side_p;
    logic [RMW-1:0] cur;
    logic [RMW-1:0] trial;

    if (k == 0) begin : g_first
      assign vld_p  = vld_in;
      assign rem_p  = '0;
      assign root_p = '0;
      assign x_p    = x;
      assign side_p = side_in;
    end else begin : g_next
      assign vld_p  = vld_q[k-1];
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
      assign x_p    = x_q[k-1];
      assign side_p = side_q[k-1];
    end

    // bring down the next bit pair, try (4*root + 1)
    assign cur   = {rem_p[RMW-3:0], x_p[DW-1-2*k -: 2]};
    assign trial = {root_p, 2'b01};

    always_ff @(posedge clk) begin
      if (cur >= trial) begin
        rem_q[k]  <= cur - trial;
        root_q[k] <= {root_p[SW-2:0], 1'b1};
      end else begin
        rem_q[k]  <= cur;
        root_q[k] <= {root_p[SW-2:0], 1'b0};
      end
      x_q[k]    <= x_p;
      side_q[k] <= side_p;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_p;
      end
    end
  end

  assign vld  = vld_q[SW-1];
  assign root = root_q[SW-1];
  assign side = side_q[SW-1];

endmodule

### src/rsi_div.sv
// Root check and restoring divider: qualifies one numerator against the
// positive and overflow limits, then forms a Q15.16 quotient one bit per
// stage. Depends on rsi_pkg.
module rsi_div #(
  parameter int AW = 64,
  parameter int NW = 68,
  parameter int XW = 31
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        vld_in,
  input  logic                        ok_in,
  input  logic signed [NW-1:0]        n,
  input  logic [AW-1:0]               a,
  input  logic [XW-1:0]               side_in,
  output logic                        vld,
  output logic                        ok,
  output logic [rsi_pkg::DIST_W-1:0]  q,
  output logic [XW-1:0]               side
);

  import rsi_pkg::*;

  localparam int QW   = DIST_W;
  localparam int SH   = QW - FRAC_W;
  localparam int CMPW = AW + QW;

  logic [CMPW-1:0]  n_mag;
  logic [CMPW-1:0]  lim;
  logic             vld_p;
  logic             ok_p;
  logic [AW-1:0]    rem_p;
  logic [QW-1:0]    lo_p;
  logic [AW-1:0]    a_p;
  logic [XW-1:0]    side_p;

  logic             vld_q  [QW];
  logic             ok_q   [QW];
  logic [AW-1:0]    rem_q  [QW];
  logic [QW-1:0]    lo_q   [QW];
  logic [AW-1:0]    a_q    [QW];
  logic [QW-1:0]    q_q    [QW];
  logic [XW-1:0]    side_q [QW];

  assign n_mag = CMPW'(n[NW-2:0]);
  assign lim   = CMPW'({a, {SH{1'b0}}});

  // a quotient of 2^31 or more saturates and can never pass the bound: drop it
  always_ff @(posedge clk) begin
    ok_p   <= ok_in && !n[NW-1] && (n != '0) && (n_mag < lim);
    rem_p  <= AW'(n_mag >> SH);
    lo_p   <= {n[SH-1:0], {FRAC_W{1'b0}}};
    a_p    <= a;
    side_p <= side_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_p <= 1'b0;
    end else begin
      vld_p <= vld_in;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic          vld_i;
    logic          ok_i;
    logic [AW-1:0] rem_i;
    logic [QW-1:0] lo_i;
    logic [AW-1:0] a_i;
    logic [QW-1:0] q_i;
    logic [XW-1:0] side_i;
    logic [AW:0]   sh;

    if (k == 0) begin : g_first
      assign vld_i  = vld_p;
      assign ok_i   = ok_p;
      assign rem_i  = rem_p;
      assign lo_i   = lo_p;
      assign a_i    = a_p;
      assign q_i    = '0;
      assign side_i = side_p;
    end else begin : g_next
      assign vld_i  = vld_q[k-1];
      assign ok_i   = ok_q[k-1];
      assign rem_i  = rem_q[k-1];
      assign lo_i   = lo_q[k-1];
      assign a_i    = a_q[k-1];
      assign q_i    = q_q[k-1];
      assign side_i = side_q[k-1];
    end

    assign sh = {rem_i, lo_i[QW-1-k]};

    always_ff @(posedge clk) begin
      if (sh >= {1'b0, a_i}) begin
        rem_q[k] <= AW'(sh - {1'b0, a_i});
        q_q[k]   <= {q_i[QW-2:0], 1'b1};
      end else begin
        rem_q[k] <= AW'(sh);
        q_q[k]   <= {q_i[QW-2:0], 1'b0};
      end
      ok_q[k]   <= ok_i;
      lo_q[k]   <= lo_i;
      a_q[k]    <= a_i;
      side_q[k] <= side_i;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_i;
      end
    end
  end

  assign vld  = vld_q[QW-1];
  assign ok   = ok_q[QW-1];
  assign q    = q_q[QW-1];
  assign side = side_q[QW-1];

endmodule

### src/ray_sphere_intersect.sv
// Top level of the ray/sphere intersection pipeline with its result queue
// and epsilon register. Depends on rsi_pkg, rsi_front, rsi_sqrt, rsi_div.
//
//   channel  signals                       direction  payload
//   input    in_valid / in_ready           in         rsi_in_t, one ray and sphere
//   result   out_valid / out_ready         out        rsi_out_t, hit and distance
//   config   cfg_wr_en / cfg_wr_data       in         epsilon, no handshake
//
// One transaction can enter per cycle while in_ready is high; every item takes
// the same fixed path of 2*COORD_WIDTH + 43 register stages (107 at the default)
// up to the queue write, most of it the one-bit-per-stage square root and the
// 31-stage divider, then the memory write and registered read to out_valid.
// Results land in a queue sized to cover the whole pipeline, so the pipeline
// never stops; in_ready drops only when queued plus in-flight items fill it.
// Reset is synchronous, clears the valid bits and counters, and loads
// epsilon with 66 (Q0.16).
module ray_sphere_intersect #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  rsi_pkg::rsi_in_t           in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output rsi_pkg::rsi_out_t          out_data,
  input  logic                       cfg_wr_en,
  input  logic [rsi_pkg::EPS_W-1:0]  cfg_wr_data
);

  import rsi_pkg::*;

  localparam int W     = COORD_WIDTH;
  localparam int AW    = 2 * W;
  localparam int HW    = 2 * W + 2;
  localparam int DW    = 4 * W + 4;
  localparam int SW    = DW / 2;
  localparam int NW    = 2 * W + 4;
  localparam int QW    = DIST_W;
  localparam int XW    = 1 + AW + HW + QW;
  localparam int LAT   = SW + QW + 10;
  localparam int DEPTH = 1 << $clog2(LAT + 2);
  localparam int PTRW  = $clog2(DEPTH);
  localparam int CNTW  = PTRW + 1;

  logic                  in_acc;
  logic                  out_acc;
  logic [EPS_W-1:0]      eps;

  logic                  f_vld;
  logic                  f_miss;
  logic [AW-1:0]         f_a;
  logic signed [HW-1:0]  f_hb;
  logic signed [DW-1:0]  f_disc;
  logic [QW-1:0]         f_maxd;

  logic                  s_vld;
  logic [SW-1:0]         s_root;
  logic [XW-1:0]         s_side;
  logic                  s_miss;
  logic [AW-1:0]         s_a;
  logic signed [HW-1:0]  s_hb;
  logic [QW-1:0]         s_maxd;

  logic                  n_vld;
  logic                  n_ok;
  logic signed [NW-1:0]  n_near;
  logic signed [NW-1:0]  n_far;
  logic [AW-1:0]         n_a;
  logic [QW-1:0]         n_maxd;

  logic                  dn_vld, df_vld;
  logic                  dn_ok, df_ok;
  logic [QW-1:0]         dn_q, df_q;
  logic [QW-1:0]         dn_maxd, df_maxd;
  logic                  near_hit, far_hit;

  logic                  wr_v;
  rsi_out_t              wr_data;
  rsi_out_t              mem [DEPTH];
  logic [PTRW-1:0]       wr_ptr;
  logic [PTRW-1:0]       rd_ptr;
  logic [CNTW-1:0]       fcnt;
  logic [CNTW-1:0]       used;
  logic                  load;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      eps <= EPS_RESET;
    end else if (cfg_wr_en) begin
      eps <= cfg_wr_data;
    end
  end

  rsi_front #(.W(W)) u_front (
    .clk     (clk),
    .rst     (rst),
    .vld_in  (in_acc),
    .in_data (in_data),
    .vld     (f_vld),
    .miss    (f_miss),
    .a       (f_a),
    .hb      (f_hb),
    .disc    (f_disc),
    .maxd    (f_maxd)
  );

  rsi_sqrt #(.DW(DW), .XW(XW)) u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .vld_in  (f_vld),
    .x       (f_disc),
    .side_in ({f_miss, f_a, f_hb, f_maxd}),
    .vld     (s_vld),
    .root    (s_root),
    .side    (s_side)
  );

  assign s_miss = s_side[XW-1];
  assign s_a    = s_side[XW-2 -: AW];
  assign s_hb   = s_side[QW+HW-1 -: HW];
  assign s_maxd = s_side[QW-1:0];

  // near and far numerators: -hb - sqrt(disc) and -hb + sqrt(disc)
  always_ff @(posedge clk) begin
    n_ok   <= !s_miss;
    n_near <= -NW'(s_hb) - NW'($signed({1'b0, s_root}));
    n_far  <= -NW'(s_hb) + NW'($signed({1'b0, s_root}));
    n_a    <= s_a;
    n_maxd <= s_maxd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n_vld <= 1'b0;
    end else begin
      n_vld <= s_vld;
    end
  end

  rsi_div #(.AW(AW), .NW(NW), .XW(QW)) u_div_near (
    .clk     (clk),
    .rst     (rst),
    .vld_in  (n_vld),
    .ok_in   (n_ok),
    .n       (n_near),
    .a       (n_a),
    .side_in (n_maxd),
    .vld     (dn_vld),
    .ok      (dn_ok),
    .q       (dn_q),
    .side    (dn_maxd)
  );

  rsi_div #(.AW(AW), .NW(NW), .XW(QW)) u_div_far (
    .clk     (clk),
    .rst     (rst),
    .vld_in  (n_vld),
    .ok_in   (n_ok),
    .n       (n_far),
    .a       (n_a),
    .side_in (n_maxd),
    .vld     (df_vld),
    .ok      (df_ok),
    .q       (df_q),
    .side    (df_maxd)
  );

  assign near_hit = dn_ok && (dn_q > QW'(eps)) && (dn_q < dn_maxd);
  assign far_hit  = df_ok && (df_q > QW'(eps)) && (df_q < df_maxd);

  // prefer the near root, fall back to the far one
  always_ff @(posedge clk) begin
    wr_data.hit <= near_hit || far_hit;
    if (near_hit) begin
      wr_data.distance <= dn_q;
    end else if (far_hit) begin
      wr_data.distance <= df_q;
    end else begin
      wr_data.distance <= '0;
    end
  end

  // result queue: write at pipeline exit, registered read into out_data
  assign load     = (fcnt != '0) && (!out_valid || out_ready);
  assign in_ready = (used < CNTW'(DEPTH));

  always_ff @(posedge clk) begin
    if (wr_v) begin
      mem[wr_ptr] <= wr_data;
    end
    if (load) begin
      out_data <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_v      <= 1'b0;
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      fcnt      <= '0;
      used      <= '0;
      out_valid <= 1'b0;
    end else begin
      // the two divider lanes run in lockstep
      wr_v <= dn_vld && df_vld;
      if (wr_v) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (load) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fcnt <= fcnt + CNTW'(wr_v) - CNTW'(load);
      used <= used + CNTW'(in_acc) - CNTW'(out_acc);
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### bench/rsi_checker.sv
`timescale 1ns / 1ps
// Result checker for ray_sphere_intersect: watches both channels and the
// epsilon port, predicts each result exactly and compares. Depends on rsi_pkg.
module rsi_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  rsi_pkg::rsi_in_t          in_data,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  rsi_pkg::rsi_out_t         out_data,
  input  logic                      cfg_wr_en,
  input  logic [rsi_pkg::EPS_W-1:0] cfg_wr_data,
  output int                        errors,
  output int                        pending,
  output int                        n_results,
  output int                        n_hits
);
  import rsi_pkg::*;

  logic [EPS_W-1:0] eps_copy;
  rsi_out_t         hits_due[$];

  // Exact intersection in wide integers; first root strictly inside (eps, max).
  function automatic rsi_out_t predict_hit(rsi_in_t x, logic [EPS_W-1:0] eps);
    logic signed [255:0] dx, dy, dz, ox, oy, oz, a, hb, c, r, disc, s, cand, num, q;
    logic [DIST_W-1:0]   t;
    rsi_out_t            res;
    res = '0;
    dx = x.direction_x;
    dy = x.direction_y;
    dz = x.direction_z;
    ox = x.origin_x;
    oy = x.origin_y;
    oz = x.origin_z;
    ox = ox - x.center_x;
    oy = oy - x.center_y;
    oz = oz - x.center_z;
    a  = dx * dx + dy * dy + dz * dz;
    hb = ox * dx + oy * dy + oz * dz;
    c  = ox * ox + oy * oy + oz * oz;
    r  = {225'b0, x.sphere_radius};
    c  = c - r * r;
    if (a == 0) return res;
    disc = hb * hb - a * c;
    if (disc < 0) return res;
    s = 0;
    for (int i = 127; i >= 0; i--) begin
      cand = s | (256'sd1 <<< i);
      if (cand * cand <= disc) s = cand;
    end
    for (int k = 0; k < 2; k++) begin
      num = (k == 0) ? -hb - s : -hb + s;
      if (num <= 0) continue;
      q = (num <<< FRAC_W) / a;
      t = (q > 256'sh7FFFFFFF) ? '1 : q[DIST_W-1:0];
      if (t > eps && t < x.max_distance) begin
        res.hit = 1'b1;
        res.distance = t;
        return res;
      end
    end
    return res;
  endfunction

  assign pending = hits_due.size();

  always @(posedge clk) begin
    rsi_out_t want;
    if (rst) begin
      eps_copy <= EPS_RESET;
      errors <= 0;
      n_results <= 0;
      n_hits <= 0;
      hits_due.delete();
    end else begin
      if (cfg_wr_en) eps_copy <= cfg_wr_data;
      if (in_valid && in_ready) hits_due.push_back(predict_hit(in_data, eps_copy));
      if (out_valid && out_ready) begin
        n_results <= n_results + 1;
        if (out_data.hit) n_hits <= n_hits + 1;
        if (hits_due.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected result transaction: hit=%0d dist=%h",
                                    out_data.hit, out_data.distance);
        end else begin
          want = hits_due.pop_front();
          if (want.hit !== out_data.hit || want.distance !== out_data.distance) begin
            errors <= errors + 1;
            if (errors < 10)
              $display("result %0d: expected hit=%0d dist=%h, got hit=%0d dist=%h",
                       n_results, want.hit, want.distance, out_data.hit, out_data.distance);
          end
        end
      end
    end
  end
endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// Stimulus and verdict for ray_sphere_intersect; prediction lives in
// rsi_checker. Depends on rsi_pkg, rsi_checker and the RTL.
module testbench;
  import rsi_pkg::*;

  localparam int LATENCY = 2 * 32 + 43;
  localparam int LIMIT   = 600000;
  localparam int IN_W    = $bits(rsi_in_t);

  logic             clk = 0;
  logic             rst = 1;
  logic             in_valid = 0;
  logic             in_ready;
  rsi_in_t          in_data = '0;
  logic             out_valid;
  logic             out_ready = 0;
  rsi_out_t         out_data;
  logic             cfg_wr_en = 0;
  logic [EPS_W-1:0] cfg_wr_data = '0;
  int               errors, pending, n_results, n_hits;
  int               cycles = 0;
  bit               hold_req = 0;
  int               burst_left = 0;

  always #4 clk = ~clk;

  ray_sphere_intersect dut (.*);

  rsi_checker chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("ray_sphere_intersect: mismatch");
      $finish;
    end
  end

  // Receiver: long hold on request, otherwise random steady or choppy stretches.
  initial begin
    int mode;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 0;
      end
      mode = $urandom_range(2);
      repeat ($urandom_range(60, 5)) begin
        @(posedge clk);
        out_ready <= (mode == 0) ? 1'b1 : ($urandom_range(3) != 0);
      end
    end
  end

  task automatic send_item(rsi_in_t x);
    bit rdy;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
      burst_left = $urandom_range(30, 1);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= x;
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
  endtask

  task automatic drain_and_set_eps(logic [EPS_W-1:0] v);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic int rnd_s(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  // Mostly rays aimed near a nearby sphere; the rest raw bit patterns.
  function automatic rsi_in_t scene_item();
    rsi_in_t x;
    int cx, cy, cz, ox, oy, oz;
    x = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom, $urandom});
    if ($urandom_range(9) < 2) return x;
    cx = rnd_s(1 << 21); cy = rnd_s(1 << 21); cz = rnd_s(1 << 21);
    ox = cx + rnd_s(1 << 22); oy = cy + rnd_s(1 << 22); oz = cz + rnd_s(1 << 22);
    x.center_x = cx; x.center_y = cy; x.center_z = cz;
    x.origin_x = ox; x.origin_y = oy; x.origin_z = oz;
    x.sphere_radius = DIST_W'($urandom_range(1 << 21, 1 << 12));
    if ($urandom_range(4) == 0) begin
      x.direction_x = rnd_s(1 << 17);
      x.direction_y = rnd_s(1 << 17);
      x.direction_z = rnd_s(1 << 17);
    end else begin
      x.direction_x = ((cx - ox) >>> $urandom_range(6)) + rnd_s(1 << 14);
      x.direction_y = ((cy - oy) >>> $urandom_range(6)) + rnd_s(1 << 14);
      x.direction_z = ((cz - oz) >>> $urandom_range(6)) + rnd_s(1 << 14);
    end
    case ($urandom_range(3))
      0: x.max_distance = '1;
      1: x.max_distance = DIST_W'($urandom_range(1 << 18));
      default: x.max_distance = DIST_W'($urandom_range(1 << 24));
    endcase
    return x;
  endfunction

  function automatic rsi_in_t simple_ray(int o, int d, int c, int rad, int mx);
    rsi_in_t x;
    x = '0;
    x.origin_x = o; x.direction_x = d; x.center_x = c;
    x.sphere_radius = DIST_W'(rad); x.max_distance = DIST_W'(mx);
    return x;
  endfunction

  initial begin
    rsi_in_t x;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    // directed, reset epsilon
    send_item(simple_ray(0, 32'h10000, 32'h50000, 32'h10000, 32'h7FFFFFFF)); // plain hit
    send_item(simple_ray(0, 0, 32'h50000, 32'h10000, 32'h7FFFFFFF));         // zero direction
    send_item(simple_ray(32'h50000, 32'h10000, 32'h50000, 32'h10000, 32'h7FFFFFFF)); // inside
    send_item(simple_ray(0, -32'sh10000, 32'h50000, 32'h10000, 32'h7FFFFFFF)); // behind
    send_item(simple_ray(0, 32'h10000, 32'h50000, 32'h10000, 32'h40000));    // bound = near root
    send_item(simple_ray(0, 32'h10000, 32'h50000, 32'h10000, 0));            // bound zero
    send_item(simple_ray(0, 32'h10000, 32'h50000, 0, 32'h7FFFFFFF));         // tangent point
    send_item(simple_ray(0, 1, 32'h7FFFFFFF, 32'h10000, 32'h7FFFFFFF));      // huge root
    x = '1;
    send_item(x);
    x = '0;
    send_item(x);
    x = {{9{32'h80000000}}, 31'h7FFFFFFF, 31'h7FFFFFFF};
    send_item(x);
    x = {{9{32'h7FFFFFFF}}, 31'h7FFFFFFF, 31'h7FFFFFFF};
    send_item(x);
    x = simple_ray(32'sh80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_item(x);
    x = simple_ray(0, 32'h10000, 32'h10000, 32'h10000, 32'h7FFFFFFF);       // root at zero
    send_item(x);
    // epsilon boundaries
    drain_and_set_eps(16'd0);
    send_item(simple_ray(0, 32'h10000, 32'h10000, 32'h10000, 32'h7FFFFFFF));
    send_item(simple_ray(0, 32'h10000, 32'h20001, 32'h10000, 32'h7FFFFFFF));
    drain_and_set_eps(16'hFFFF);
    send_item(simple_ray(0, 32'h10000, 32'h1FFFF, 32'h10000, 32'h7FFFFFFF)); // root = eps
    send_item(simple_ray(0, 32'h10000, 32'h20000, 32'h10000, 32'h7FFFFFFF)); // just above
    send_item(simple_ray(32'h10000, 32'h10000, 32'h10000, 32'h10000, 32'h7FFFFFFF));
    // random phases over several epsilon settings, long receiver hold in one
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: drain_and_set_eps(16'd66);
        1: drain_and_set_eps(16'hFFFF);
        2: drain_and_set_eps(16'd0);
        default: drain_and_set_eps(EPS_W'($urandom));
      endcase
      if (ph == 1) hold_req = 1;
      repeat (210) send_item(scene_item());
    end
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    $display("ran %0d rays through four epsilon settings, %0d hits, %0d misses",
             n_results, n_hits, n_results - n_hits);
    if (errors == 0 && pending == 0)
      $display("ray_sphere_intersect: match");
    else
      $display("ray_sphere_intersect: mismatch");
    $finish;
  end
endmodule

### filelist.f
src/rsi_pkg.sv
src/rsi_mul.sv
src/rsi_front.sv
src/rsi_sqrt.sv
src/rsi_div.sv
src/ray_sphere_intersect.sv
bench/rsi_checker.sv
bench/testbench.sv
